[rtl/wpsteer_pkg.sv]
package wpsteer_pkg;

    // Field widths
    localparam int COORD_WIDTH    = 24;
    localparam int OFFSET_WIDTH   = 17;
    localparam int HEADING_WIDTH  = 16;
    localparam int REG_WIDTH      = 16;
    localparam int CFG_AW         = 2;
    localparam int DIR_WIDTH      = 2;
    localparam int AMT_WIDTH      = 16;
    localparam int ERR_WIDTH      = 17;

    // Input beat layout, lowest field first
    localparam int TX_LSB  = 0;
    localparam int TY_LSB  = TX_LSB + COORD_WIDTH;
    localparam int CX_LSB  = TY_LSB + COORD_WIDTH;
    localparam int CY_LSB  = CX_LSB + COORD_WIDTH;
    localparam int OX_LSB  = CY_LSB + COORD_WIDTH;
    localparam int OY_LSB  = OX_LSB + OFFSET_WIDTH;
    localparam int HD_LSB  = OY_LSB + OFFSET_WIDTH;
    localparam int IN_BITS = HD_LSB + HEADING_WIDTH;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = DIR_WIDTH + AMT_WIDTH + ERR_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // CORDIC datapath
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_DEPTH  = 24;
    localparam int ATAN_IW     = $clog2(ATAN_DEPTH);
    localparam int ATAN_WIDTH  = 22;
    localparam int DIFF_WIDTH  = ((COORD_WIDTH > OFFSET_WIDTH) ? COORD_WIDTH : OFFSET_WIDTH) + 2;
    localparam int SCALE_SHIFT = 56 - COORD_WIDTH;
    localparam int XW          = DIFF_WIDTH + SCALE_SHIFT + 2;
    localparam int ZW          = 27;
    localparam int ZQW         = ZW - 8;
    localparam int DEG180_Z    = 180 * 65536;

    localparam int DEG180_Q8 = 46080;
    localparam int DEG360_Q8 = 92160;
    localparam int WRAP_W    = 19;

    // Heading reduction: floor(h / 360) = (h * HDG_RECIP) >> HDG_RECIP_SHIFT for h < 2^15+1
    localparam int HDG_MOD         = 360;
    localparam int HDG_RECIP       = 46604;
    localparam int HDG_RECIP_SHIFT = 24;
    localparam int HDG_QW          = 7;
    localparam int HDG_REMW        = 9;
    localparam int CUR_W           = 18;

    // Shared multiplier: unsigned REG_WIDTH operand times signed MB_W operand
    localparam int MB_W = 18;
    localparam int PW   = REG_WIDTH + 1 + MB_W;
    localparam int AW   = PW + 1;
    localparam int MAG_SHIFT = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ITER,
        ST_ANGLE,
        ST_WRAP,
        ST_MULP,
        ST_MULD,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_DERIV_GAIN  = 2'd1,
        REG_MAX_CONTROL = 2'd2,
        REG_DEADBAND    = 2'd3
    } cfg_reg_t;

    typedef enum logic [DIR_WIDTH-1:0] {
        STEER_NONE  = 2'd0,
        STEER_RIGHT = 2'd1,
        STEER_LEFT  = 2'd2
    } steer_dir_t;

    localparam logic [REG_WIDTH-1:0] PROP_GAIN_RST   = 16'd1638;
    localparam logic [REG_WIDTH-1:0] DERIV_GAIN_RST  = 16'd1638;
    localparam logic [REG_WIDTH-1:0] MAX_CONTROL_RST = 16'd24576;
    localparam logic [REG_WIDTH-1:0] DEADBAND_RST    = 16'd768;

    // atan(2^-i) in degrees Q.16
    function automatic logic [ATAN_WIDTH-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
        logic [ATAN_WIDTH-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/waypoint_heading_pd_steer.sv]
// From the accepted input beat to the output beat going valid: setup,
// CORDIC_ITERATIONS CORDIC steps, then six steps for wrap and gain products.
// One item at a time, set by the single CORDIC step unit and the one shared multiplier;
// a held output stalls the last step.
// Reset (rst_n low, asynchronous): sequencer idle, output empty, last error zero,
// gains, clamp and deadband at their defaults.
module waypoint_heading_pd_steer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wpsteer_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [wpsteer_pkg::REG_WIDTH-1:0]   cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_x, target_y, car_x, car_y, offset_x, offset_y, heading_deg, zero pad
    input  logic [wpsteer_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // steer_dir, steer_amount, heading_error, zero pad
    output logic [wpsteer_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import wpsteer_pkg::*;

    localparam logic [ATAN_IW-1:0] IT_LAST = ATAN_IW'(CORDIC_ITERATIONS - 1);
    localparam logic signed [ZQW-1:0] ZQ_MAX = ZQW'(DEG180_Q8);
    localparam logic signed [ZQW-1:0] ZQ_MIN = -ZQW'(DEG180_Q8);
    localparam logic signed [WRAP_W-1:0] WR_MAX = WRAP_W'(DEG180_Q8);
    localparam logic signed [WRAP_W-1:0] WR_MIN = -WRAP_W'(DEG180_Q8);
    localparam logic signed [WRAP_W-1:0] WR_TURN = WRAP_W'(DEG360_Q8);
    localparam logic signed [ERR_WIDTH-1:0] ERR_MAX = ERR_WIDTH'(DEG180_Q8);
    localparam logic signed [ERR_WIDTH-1:0] ERR_MIN = -ERR_WIDTH'(DEG180_Q8);

    state_t state_reg, state_next;
    logic   accept;
    logic   out_load;

    logic [REG_WIDTH-1:0] prop_gain_reg, deriv_gain_reg, max_control_reg, deadband_reg;

    logic signed [DIFF_WIDTH-1:0] dx_reg, dy_reg;
    logic [HEADING_WIDTH-1:0]     habs_reg;
    logic                         hneg_reg;
    logic                         zero_reg;

    logic signed [XW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [ATAN_IW-1:0]      it_reg;

    logic signed [ERR_WIDTH-1:0] ang_reg;
    logic signed [CUR_W-1:0]     cur_reg;
    logic signed [ERR_WIDTH-1:0] err_reg;
    logic signed [ERR_WIDTH-1:0] last_err_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [AW-1:0]        acc_reg;

    logic                        m_valid_reg;
    steer_dir_t                  out_dir_reg;
    logic [AMT_WIDTH-1:0]        out_amt_reg;
    logic signed [ERR_WIDTH-1:0] out_err_reg;

    // Input unpack and difference vector
    logic signed [COORD_WIDTH-1:0]   tx, ty, cx, cy;
    logic signed [OFFSET_WIDTH-1:0]  ox, oy;
    logic signed [HEADING_WIDTH-1:0] hd;
    logic signed [HEADING_WIDTH:0]   hd_e;
    logic signed [DIFF_WIDTH-1:0]    dx_w, dy_w;
    logic [HEADING_WIDTH-1:0]        habs_w;

    assign tx = s_axis_tdata[TX_LSB +: COORD_WIDTH];
    assign ty = s_axis_tdata[TY_LSB +: COORD_WIDTH];
    assign cx = s_axis_tdata[CX_LSB +: COORD_WIDTH];
    assign cy = s_axis_tdata[CY_LSB +: COORD_WIDTH];
    assign ox = s_axis_tdata[OX_LSB +: OFFSET_WIDTH];
    assign oy = s_axis_tdata[OY_LSB +: OFFSET_WIDTH];
    assign hd = s_axis_tdata[HD_LSB +: HEADING_WIDTH];

    always_comb
    begin
        dx_w   = DIFF_WIDTH'(tx) - (DIFF_WIDTH'(cx) + DIFF_WIDTH'(ox));
        dy_w   = DIFF_WIDTH'(ty) - (DIFF_WIDTH'(cy) + DIFF_WIDTH'(oy));
        hd_e   = (HEADING_WIDTH + 1)'(hd);
        habs_w = hd[HEADING_WIDTH-1] ? HEADING_WIDTH'(-hd_e) : HEADING_WIDTH'(hd_e);
    end

    // CORDIC setup: scale up, turn half a circle when x is negative
    logic signed [XW-1:0] x_base, y_base, x_init, y_init;
    logic signed [ZW-1:0] z_init;

    always_comb
    begin
        x_base = XW'($signed({dx_reg, {SCALE_SHIFT{1'b0}}}));
        y_base = XW'($signed({dy_reg, {SCALE_SHIFT{1'b0}}}));
        if (dx_reg[DIFF_WIDTH-1])
        begin
            x_init = -x_base;
            y_init = -y_base;
            z_init = dy_reg[DIFF_WIDTH-1] ? -ZW'(DEG180_Z) : ZW'(DEG180_Z);
        end
        else
        begin
            x_init = x_base;
            y_init = y_base;
            z_init = '0;
        end
    end

    // Shared CORDIC step unit
    logic signed [XW-1:0] x_sh, y_sh, x_step, y_step;
    logic signed [ZW-1:0] atan_z, z_step;

    always_comb
    begin
        x_sh   = x_reg >>> it_reg;
        y_sh   = y_reg >>> it_reg;
        atan_z = $signed(ZW'(atan_q16(it_reg)));
        if (!y_reg[XW-1])
        begin
            x_step = x_reg + y_sh;
            y_step = y_reg - x_sh;
            z_step = z_reg + atan_z;
        end
        else
        begin
            x_step = x_reg - y_sh;
            y_step = y_reg + x_sh;
            z_step = z_reg - atan_z;
        end
    end

    // Angle rounding and heading remainder
    logic signed [ZW-1:0]      z_rnd;
    logic signed [ZQW-1:0]     z_q8;
    logic signed [ERR_WIDTH-1:0] ang_w;
    logic [HDG_QW-1:0]         hq;
    logic [HEADING_WIDTH:0]    hrem_full;
    logic [HDG_REMW-1:0]       hrem;
    logic signed [CUR_W-1:0]   cur_mag, cur_w;

    always_comb
    begin
        z_rnd = z_reg + ZW'(128);
        z_q8  = z_rnd[ZW-1:8];
        if (zero_reg)
            ang_w = '0;
        else if (z_q8 > ZQ_MAX)
            ang_w = ERR_MAX;
        else if (z_q8 < ZQ_MIN)
            ang_w = ERR_MIN;
        else
            ang_w = ERR_WIDTH'(z_q8);

        hq        = prod_reg[HDG_RECIP_SHIFT +: HDG_QW];
        hrem_full = (HEADING_WIDTH + 1)'(habs_reg)
                    - (HEADING_WIDTH + 1)'(hq) * (HEADING_WIDTH + 1)'(HDG_MOD);
        hrem      = hrem_full[HDG_REMW-1:0];
        cur_mag   = $signed({1'b0, hrem, 8'b0});
        cur_w     = hneg_reg ? -cur_mag : cur_mag;
    end

    // Error wrap into one half turn either way
    logic signed [WRAP_W-1:0] err_raw, err_wrap;

    always_comb
    begin
        err_raw = WRAP_W'(ang_reg) - WRAP_W'(cur_reg);
        priority if (err_raw > WR_MAX)
            err_wrap = err_raw - WR_TURN;
        else if (err_raw < WR_MIN)
            err_wrap = err_raw + WR_TURN;
        else
            err_wrap = err_raw;
    end

    // Shared multiplier
    logic [REG_WIDTH-1:0]     mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PW-1:0]     mul_p;

    always_comb
    begin
        unique case (state_reg)
            ST_SETUP:
            begin
                mul_a = REG_WIDTH'(HDG_RECIP);
                mul_b = $signed(MB_W'(habs_reg));
            end
            ST_MULP:
            begin
                mul_a = prop_gain_reg;
                mul_b = MB_W'(err_reg);
            end
            ST_MULD:
            begin
                mul_a = deriv_gain_reg;
                mul_b = MB_W'(err_reg) - MB_W'(last_err_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = $signed({1'b0, mul_a}) * mul_b;
    end

    // Drive magnitude, clamp and direction
    logic signed [AW-1:0]      acc_abs;
    logic [AW-MAG_SHIFT-1:0]   mag;
    logic [AMT_WIDTH-1:0]      amt_w;
    logic signed [ERR_WIDTH:0] db_s, err_s;
    steer_dir_t                dir_w;

    always_comb
    begin
        acc_abs = acc_reg[AW-1] ? -acc_reg : acc_reg;
        mag     = acc_abs[AW-1:MAG_SHIFT];
        amt_w   = (mag > (AW - MAG_SHIFT)'(max_control_reg)) ? max_control_reg
                                                              : mag[AMT_WIDTH-1:0];
        db_s    = $signed((ERR_WIDTH + 1)'(deadband_reg));
        err_s   = (ERR_WIDTH + 1)'(err_reg);
        priority if (err_s < -db_s)
            dir_w = STEER_RIGHT;
        else if (err_s > db_s)
            dir_w = STEER_LEFT;
        else
            dir_w = STEER_NONE;
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_ITER;
            ST_ITER:  if (it_reg == IT_LAST) state_next = ST_ANGLE;
            ST_ANGLE: state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_MULP;
            ST_MULP:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DONE: out_load = !m_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            last_err_reg    <= '0;
            prop_gain_reg   <= PROP_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            max_control_reg <= MAX_CONTROL_RST;
            deadband_reg    <= DEADBAND_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg  <= 1'b1;
                last_err_reg <= err_reg;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                    REG_MAX_CONTROL: max_control_reg <= cfg_data;
                    REG_DEADBAND:    deadband_reg    <= cfg_data;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg   <= dx_w;
            dy_reg   <= dy_w;
            habs_reg <= habs_w;
            hneg_reg <= hd[HEADING_WIDTH-1];
        end
        unique case (state_reg)
            ST_SETUP:
            begin
                x_reg    <= x_init;
                y_reg    <= y_init;
                z_reg    <= z_init;
                it_reg   <= '0;
                zero_reg <= (dx_reg == '0) && (dy_reg == '0);
                prod_reg <= mul_p;
            end
            ST_ITER:
            begin
                x_reg  <= x_step;
                y_reg  <= y_step;
                z_reg  <= z_step;
                it_reg <= it_reg + 1'b1;
            end
            ST_ANGLE:
            begin
                ang_reg <= ang_w;
                cur_reg <= cur_w;
            end
            ST_WRAP:
            begin
                err_reg <= err_wrap[ERR_WIDTH-1:0];
            end
            ST_MULP:
            begin
                prod_reg <= mul_p;
            end
            ST_MULD:
            begin
                acc_reg  <= AW'(prod_reg);
                prod_reg <= mul_p;
            end
            ST_SUM:
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_dir_reg <= dir_w;
            out_amt_reg <= (dir_w == STEER_NONE) ? '0 : amt_w;
            out_err_reg <= err_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                            out_err_reg, out_amt_reg, out_dir_reg};

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted beat did not start the sequencer");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_DONE && $stable(out_err_reg)))
        else $error("result overwrote a held output beat");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ITER |-> it_reg <= IT_LAST)
        else $error("CORDIC step counter ran past the last step");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && out_dir_reg == STEER_NONE) |-> out_amt_reg == '0)
        else $error("steer amount nonzero without a direction");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (out_err_reg <= ERR_MAX && out_err_reg >= ERR_MIN))
        else $error("heading error outside one half turn");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import wpsteer_pkg::*;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) <<< (COORD_WIDTH - 1));
    localparam longint OFS_HI   = (longint'(1) <<< (OFFSET_WIDTH - 1)) - 1;
    localparam longint OFS_LO   = -(longint'(1) <<< (OFFSET_WIDTH - 1));
    localparam longint HDG_HI   = (longint'(1) <<< (HEADING_WIDTH - 1)) - 1;
    localparam longint HDG_LO   = -(longint'(1) <<< (HEADING_WIDTH - 1));
    localparam int RANDOM_ITEMS = 1426;

    typedef struct {
        logic signed [COORD_WIDTH-1:0]   tx;
        logic signed [COORD_WIDTH-1:0]   ty;
        logic signed [COORD_WIDTH-1:0]   cx;
        logic signed [COORD_WIDTH-1:0]   cy;
        logic signed [OFFSET_WIDTH-1:0]  ox;
        logic signed [OFFSET_WIDTH-1:0]  oy;
        logic signed [HEADING_WIDTH-1:0] hd;
    } waypoint_fix_t;

    typedef struct {
        steer_dir_t                   dir;
        logic [AMT_WIDTH-1:0]         amount;
        logic signed [ERR_WIDTH-1:0]  err;
    } steer_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr = '0;
    logic [REG_WIDTH-1:0]   cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // atan(2^-i) in degrees Q.16
    longint atan_step_q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // predictor state and register copies
    longint gain_p, gain_d, clamp_amt, dead_q8, prev_err_q8;

    steer_result_t pending_steer [$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  config_sets = 0;
    bit  quiet = 1'b0;

    waypoint_heading_pd_steer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending_steer.size());
        $display("** waypoint_heading_pd_steer: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic longint rand_signed(input int n);
        logic [63:0] w;
        w = {$urandom, $urandom};
        return longint'(w << (64 - n)) >>> (64 - n);
    endfunction

    function automatic waypoint_fix_t make_fix(input longint tx, ty, cx, cy, ox, oy, hd);
        waypoint_fix_t f;
        f.tx = COORD_WIDTH'(tx);
        f.ty = COORD_WIDTH'(ty);
        f.cx = COORD_WIDTH'(cx);
        f.cy = COORD_WIDTH'(cy);
        f.ox = OFFSET_WIDTH'(ox);
        f.oy = OFFSET_WIDTH'(oy);
        f.hd = HEADING_WIDTH'(hd);
        return f;
    endfunction

    // vectoring CORDIC bearing of (dx, dy), degrees Q.8
    function automatic longint bearing_q8(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx <<< SCALE_SHIFT;
        y = dy <<< SCALE_SHIFT;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? DEG180_Z : -DEG180_Z;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step_q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step_q16[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z > DEG180_Q8)
            z = DEG180_Q8;
        if (z < -DEG180_Q8)
            z = -DEG180_Q8;
        return z;
    endfunction

    function automatic steer_result_t predict_steer(input waypoint_fix_t f);
        steer_result_t r;
        longint dx, dy, err, drive, mag;
        dx = longint'(f.tx) - (longint'(f.cx) + longint'(f.ox));
        dy = longint'(f.ty) - (longint'(f.cy) + longint'(f.oy));
        // heading remainder truncates toward zero
        err = bearing_q8(dx, dy) - (longint'(f.hd) % 360) * 256;
        while (err > DEG180_Q8)
            err = err - DEG360_Q8;
        while (err < -DEG180_Q8)
            err = err + DEG360_Q8;
        drive = gain_p * err + gain_d * (err - prev_err_q8);
        mag = ((drive < 0) ? -drive : drive) >>> MAG_SHIFT;
        if (mag > clamp_amt)
            mag = clamp_amt;
        r.dir = STEER_NONE;
        r.amount = '0;
        if (err < -dead_q8)
        begin
            r.dir = STEER_RIGHT;
            r.amount = mag[AMT_WIDTH-1:0];
        end
        else if (err > dead_q8)
        begin
            r.dir = STEER_LEFT;
            r.amount = mag[AMT_WIDTH-1:0];
        end
        r.err = err[ERR_WIDTH-1:0];
        prev_err_q8 = err;
        return r;
    endfunction

    function automatic waypoint_fix_t random_fix();
        int pick;
        longint cx, cy, ox, oy, dx, dy, hd;
        pick = $urandom_range(99);
        if (pick < 35)
            return make_fix(rand_signed(COORD_WIDTH), rand_signed(COORD_WIDTH),
                            rand_signed(COORD_WIDTH), rand_signed(COORD_WIDTH),
                            rand_signed(OFFSET_WIDTH), rand_signed(OFFSET_WIDTH),
                            rand_signed(HEADING_WIDTH));
        // local geometry: waypoint a short way from the aim point
        cx = rand_signed(COORD_WIDTH - 2);
        cy = rand_signed(COORD_WIDTH - 2);
        ox = rand_signed(OFFSET_WIDTH);
        oy = rand_signed(OFFSET_WIDTH);
        dx = ($urandom_range(3) == 0) ? rand_signed(5) : rand_signed(13);
        dy = ($urandom_range(3) == 0) ? rand_signed(5) : rand_signed(13);
        if (pick >= 90)
        begin
            case ($urandom_range(2))
                0: begin dx = 0; dy = 0; end
                1: dx = 0;
                default: dy = 0;
            endcase
        end
        if (pick >= 75 && pick < 90)
            // aim close to the bearing, with a random turn count
            hd = bearing_q8(dx, dy) / 256 + longint'($urandom_range(8)) - 4
                 + 360 * (longint'($urandom_range(160)) - 80);
        else if ($urandom_range(1) == 0)
            hd = rand_signed(10);
        else
            hd = rand_signed(HEADING_WIDTH);
        return make_fix(cx + ox + dx, cy + oy + dy, cx, cy, ox, oy, hd);
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic send_item(input waypoint_fix_t f);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}},
                          f.hd, f.oy, f.ox, f.cy, f.cx, f.ty, f.tx};
        do @(posedge clk); while (!s_axis_tready);
        pending_steer.push_back(predict_steer(f));
        items_sent++;
    endtask

    // drop valid, hold until every result is back, then let the sequencer settle
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [REG_WIDTH-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
    endtask

    task automatic apply_config(input logic [REG_WIDTH-1:0] p, d, m, db);
        wait_for_results();
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_MAX_CONTROL, m);
        write_reg(REG_DEADBAND, db);
        @(negedge clk);
        cfg_we <= 1'b0;
        gain_p    = p;
        gain_d    = d;
        clamp_amt = m;
        dead_q8   = db;
        config_sets++;
    endtask

    function automatic logic [REG_WIDTH-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return '1;
            1:       return REG_WIDTH'($urandom_range(4000));
            2:       return REG_WIDTH'($urandom_range(65535));
            default: return PROP_GAIN_RST;
        endcase
    endfunction

    task automatic random_config();
        logic [REG_WIDTH-1:0] p, d, m, db;
        p = pick_gain();
        d = pick_gain();
        case ($urandom_range(3))
            0:       m = '0;
            1:       m = '1;
            2:       m = MAX_CONTROL_RST;
            default: m = REG_WIDTH'($urandom_range(65535));
        endcase
        case ($urandom_range(3))
            0:       db = '0;
            1:       db = REG_WIDTH'($urandom_range(3000));
            2:       db = REG_WIDTH'(256 * $urandom_range(20));
            default: db = REG_WIDTH'($urandom_range(65535));
        endcase
        apply_config(p, d, m, db);
    endtask

    // geometry and heading corners at the reset register values
    task automatic test_reset_defaults();
        send_item(make_fix(0, 0, 0, 0, 0, 0, 0));
        send_item(make_fix(100, -5, 90, -5, 10, 0, 45));
        send_item(make_fix(COORD_HI, 0, COORD_LO, 0, OFS_LO, 0, 0));
        // due west lands exactly on +180 and stays there
        send_item(make_fix(COORD_LO, 0, COORD_HI, 0, OFS_HI, 0, 0));
        send_item(make_fix(COORD_LO, -1, COORD_HI, 0, 0, 0, -90));
        send_item(make_fix(0, COORD_HI, 0, COORD_LO, 0, OFS_LO, HDG_HI));
        send_item(make_fix(0, COORD_LO, 0, COORD_HI, 0, OFS_HI, HDG_LO));
        send_item(make_fix(16, 16, 0, 0, 0, 0, 360));
        send_item(make_fix(-16, 16, 0, 0, 0, 0, -359));
        send_item(make_fix(16, -16, 0, 0, 0, 0, 359));
        send_item(make_fix(-1000, 176, 0, 0, 0, 0, -170));
        send_item(make_fix(-1000, -176, 0, 0, 0, 0, 170));
        // error right at the deadband edges, then just past
        send_item(make_fix(1000, 0, 0, 0, 0, 0, -3));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 3));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 4));
    endtask

    task automatic test_register_extremes();
        apply_config('1, '1, '1, '0);
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 180));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, -179));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 0));
        apply_config('1, '1, '0, '0);
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 90));
        apply_config('1, '1, '1, REG_WIDTH'(DEG180_Q8));
        send_item(make_fix(-1000, 0, 0, 0, 0, 0, 0));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 180));
        // deadband above the error range: never steers
        apply_config('1, '1, '1, '1);
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 100));
        apply_config('0, '0, '1, '0);
        send_item(make_fix(1000, 0, 0, 0, 0, 0, 1));
        send_item(make_fix(1000, 0, 0, 0, 0, 0, -1));
    endtask

    task automatic test_random_traffic(input int total);
        int left, burst, phase;
        left = total;
        phase = 0;
        while (left > 0)
        begin
            burst = $urandom_range(140, 60);
            if (burst > left)
                burst = left;
            random_config();
            quiet = (phase % 5 == 3);
            repeat (burst) send_item(random_fix());
            left = left - burst;
            phase++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        steer_result_t               want;
        logic [DIR_WIDTH-1:0]        got_dir;
        logic [AMT_WIDTH-1:0]        got_amt;
        logic signed [ERR_WIDTH-1:0] got_err;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_dir = m_axis_tdata[DIR_WIDTH-1:0];
            got_amt = m_axis_tdata[DIR_WIDTH +: AMT_WIDTH];
            got_err = m_axis_tdata[DIR_WIDTH + AMT_WIDTH +: ERR_WIDTH];
            results_seen++;
            if (pending_steer.size() == 0)
                note_failure($sformatf("unexpected beat: dir %0d amount %0d error %0d",
                                       got_dir, got_amt, got_err));
            else
            begin
                want = pending_steer.pop_front();
                if (got_dir !== want.dir || got_amt !== want.amount || got_err !== want.err)
                    note_failure($sformatf(
                        "result %0d: dir %0d/%0d amount %0d/%0d error %0d/%0d (exp/got)",
                        results_seen, want.dir, got_dir, want.amount, got_amt,
                        want.err, got_err));
            end
        end
    end

    initial
    begin : run_tests
        int directed;
        gain_p      = PROP_GAIN_RST;
        gain_d      = DERIV_GAIN_RST;
        clamp_amt   = MAX_CONTROL_RST;
        dead_q8     = DEADBAND_RST;
        prev_err_q8 = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        directed = items_sent;
        test_random_traffic(RANDOM_ITEMS);

        wait_for_results();
        repeat (30) @(negedge clk);

        $display("sent %0d fixes (%0d directed, %0d random) across %0d register settings",
                 items_sent, directed, items_sent - directed, config_sets);
        $display("checked %0d steering results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_steer.size() == 0)
            $display("** waypoint_heading_pd_steer: PASSED **");
        else
            $display("** waypoint_heading_pd_steer: FAILED **");
        $finish;
    end

endmodule
